/* hdl/ltlp_pkg.sv */
// Shared types and constants for the lock table.
package ltlp_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int ST_W   = 2;
  localparam int LIVE_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_PROMOTE = 2'd2,
    OP_GET     = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_OUT
  } state_t;

endpackage

/* hdl/ltlp_req_if.sv */
// Request channel: operation, key and requested lock type.
interface ltlp_req_if;
  logic                          valid;
  logic                          ready;
  logic [ltlp_pkg::OP_W-1:0]     operation;
  logic [ltlp_pkg::KEY_W-1:0]    lock_key;
  logic                          requested_type;

  modport source (output valid, operation, lock_key, requested_type, input ready);
  modport sink   (input valid, operation, lock_key, requested_type, output ready);
endinterface

/* hdl/ltlp_rsp_if.sv */
// Response channel: status, held type and live entry count.
interface ltlp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ltlp_pkg::ST_W-1:0]     status;
  logic                          held_type;
  logic [ltlp_pkg::LIVE_W-1:0]   live_count;
  logic                          is_empty;
  logic                          is_full;

  modport source (output valid, status, held_type, live_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, held_type, live_count, is_empty, is_full,
                  output ready);
endinterface

/* hdl/ltlp_slot_ram.sv */
// Slot memory: one write port, one read port with registered read data.
module ltlp_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ltlp_hash.sv */
// Home slot unit: key modulo SLOTS, a mask when SLOTS is 2^n, else a reciprocal multiply.
module ltlp_hash #(
  parameter int SLOTS = 16,
  parameter int KB    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KB-1:0]            key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);

  localparam int          IDXW    = $clog2(SLOTS);
  localparam bit          POW2    = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(SLOTS));
  localparam logic [31:0] DIVISOR = 32'(SLOTS);

  logic            busy;
  logic [1:0]      step;
  logic [31:0]     kreg;
  logic [31:0]     quo;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [IDXW:0]   diff;
  logic [IDXW-1:0] rem_next;

  // shared multiplier: quotient estimate first, then quotient times SLOTS
  always_comb begin
    if (step == 2'd0) begin
      mul_a = kreg;
      mul_b = RECIP;
    end else begin
      mul_a = quo;
      mul_b = DIVISOR;
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // estimate is low by at most one, so one compare and subtract finishes it
  always_comb begin
    if (diff >= (IDXW+1)'(SLOTS)) begin
      rem_next = IDXW'(diff - (IDXW+1)'(SLOTS));
    end else begin
      rem_next = IDXW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (POW2) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && step == 2'd2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= 32'(key);
      step <= '0;
      home <= IDXW'(key);
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd0) begin
        quo <= mul_p[63:32];
      end
      if (step == 2'd1) begin
        diff <= kreg[IDXW:0] - mul_p[IDXW:0];
      end
      if (step == 2'd2) begin
        home <= rem_next;
      end
    end
  end

endmodule

/* hdl/lock_table_linear_probe.sv */
// Lock table: open-addressed hash table with linear probing and tombstones.
//
// req (sink): operation, lock_key, requested_type. rsp (source): status,
// held_type, live_count, is_empty, is_full. A transfer happens on valid & ready.
// One request is handled at a time; req.ready is high only while idle.
// From request transfer to rsp.valid: a hash phase (a mask when SLOTS is a
// power of two, else a reciprocal multiply, a multiply back and a compare
// and subtract on one shared multiplier), then one cycle per probed slot
// (1..SLOTS, one read of the slot memory each), then the load of the output
// register once it is free. An add to a full table skips hashing and
// probing. The next request is taken the cycle after the result is loaded.
// Reset runs a clearing pass over every slot of the slot memory; req.ready
// stays low until it ends. A result waits in the output register while rsp is
// stalled; the next request may be taken meanwhile and holds at its own end
// until the register is free.
module lock_table_linear_probe #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  ltlp_req_if.sink   req,
  ltlp_rsp_if.source rsp
);

  localparam int KB   = (KEY_BITS < ltlp_pkg::KEY_W) ? KEY_BITS : ltlp_pkg::KEY_W;
  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic          used;
    logic          deleted;
    logic          ltype;
    logic [KB-1:0] key;
  } slot_t;

  localparam int SW = $bits(slot_t);

  ltlp_pkg::state_t  state, state_next;
  ltlp_pkg::op_t     op;
  logic [KB-1:0]     key;
  logic              rtype;
  logic [IDXW-1:0]   probe, probe_next;
  logic [CNTW-1:0]   pcnt, pcnt_next;
  logic [CNTW-1:0]   count, count_next;
  ltlp_pkg::status_t res_status, res_status_next;
  logic              res_held, res_held_next;
  logic              res_load;

  logic              out_valid;
  ltlp_pkg::status_t out_status;
  logic              out_held;
  logic [CNTW-1:0]   out_count;

  logic              we;
  logic [IDXW-1:0]   waddr, raddr;
  slot_t             wdata, rd;
  logic [SW-1:0]     rdata;
  logic              hstart, hdone;
  logic [IDXW-1:0]   hhome;
  logic              accept, out_free;
  logic              slot_free, slot_hit, last_probe, probe_end;
  logic [IDXW-1:0]   probe_inc;

  ltlp_slot_ram #(.DEPTH(SLOTS), .WIDTH(SW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ltlp_hash #(.SLOTS(SLOTS), .KB(KB)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hstart),
    .key   (req.lock_key[KB-1:0]),
    .done  (hdone),
    .home  (hhome)
  );

  assign req.ready      = (state == ltlp_pkg::S_IDLE);
  assign accept         = req.valid && req.ready;
  assign out_free       = !out_valid || rsp.ready;
  assign rd             = slot_t'(rdata);
  assign probe_inc      = (probe == IDXW'(SLOTS - 1)) ? '0 : probe + IDXW'(1);
  assign slot_free      = !rd.used || rd.deleted;
  assign slot_hit       = rd.used && !rd.deleted && (rd.key == key);
  assign last_probe     = (pcnt == CNTW'(SLOTS - 1));

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.held_type  = out_held;
  assign rsp.live_count = ltlp_pkg::LIVE_W'(out_count);
  assign rsp.is_empty   = (out_count == '0);
  assign rsp.is_full    = (out_count == CNTW'(SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltlp_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    probe_next      = probe;
    pcnt_next       = pcnt;
    count_next      = count;
    res_status_next = res_status;
    res_held_next   = res_held;
    res_load        = 1'b0;
    hstart          = 1'b0;
    we              = 1'b0;
    waddr           = probe;
    wdata           = rd;
    raddr           = probe;
    probe_end       = 1'b0;
    unique case (state)
      ltlp_pkg::S_CLEAR: begin
        we           = 1'b1;
        wdata        = '0;
        probe_next   = probe_inc;
        if (probe == IDXW'(SLOTS - 1)) begin
          state_next = ltlp_pkg::S_IDLE;
        end
      end
      ltlp_pkg::S_IDLE: begin
        if (accept) begin
          if (ltlp_pkg::op_t'(req.operation) == ltlp_pkg::OP_ADD &&
              count == CNTW'(SLOTS)) begin
            res_status_next = ltlp_pkg::ST_FULL;
            res_held_next   = 1'b0;
            state_next      = ltlp_pkg::S_OUT;
          end else begin
            hstart     = 1'b1;
            state_next = ltlp_pkg::S_HASH;
          end
        end
      end
      ltlp_pkg::S_HASH: begin
        if (hdone) begin
          raddr      = hhome;
          probe_next = hhome;
          pcnt_next  = '0;
          state_next = ltlp_pkg::S_PROBE;
        end
      end
      ltlp_pkg::S_PROBE: begin
        res_held_next = 1'b0;
        if (op == ltlp_pkg::OP_ADD) begin
          priority if (slot_free) begin
            we              = 1'b1;
            wdata.used      = 1'b1;
            wdata.deleted   = 1'b0;
            wdata.ltype     = rtype;
            wdata.key       = key;
            count_next      = count + CNTW'(1);
            res_status_next = ltlp_pkg::ST_OK;
            probe_end       = 1'b1;
          end else if (slot_hit) begin
            res_status_next = ltlp_pkg::ST_CONFLICT;
            probe_end       = 1'b1;
          end else if (last_probe) begin
            res_status_next = ltlp_pkg::ST_FULL;
            probe_end       = 1'b1;
          end else begin
            probe_end       = 1'b0;
          end
        end else begin
          priority if (!rd.used) begin
            res_status_next = ltlp_pkg::ST_NOT_FOUND;
            probe_end       = 1'b1;
          end else if (slot_hit) begin
            res_status_next = ltlp_pkg::ST_OK;
            probe_end       = 1'b1;
            unique case (op)
              ltlp_pkg::OP_REMOVE: begin
                we            = 1'b1;
                wdata.deleted = 1'b1;
                if (count != '0) begin
                  count_next  = count - CNTW'(1);
                end
              end
              ltlp_pkg::OP_PROMOTE: begin
                we          = 1'b1;
                wdata.ltype = 1'b1;
              end
              ltlp_pkg::OP_GET: begin
                res_held_next = rd.ltype;
              end
              default: begin
                we = 1'b0;
              end
            endcase
          end else if (last_probe) begin
            res_status_next = ltlp_pkg::ST_NOT_FOUND;
            probe_end       = 1'b1;
          end else begin
            probe_end       = 1'b0;
          end
        end
        if (probe_end) begin
          state_next = ltlp_pkg::S_OUT;
        end else begin
          raddr      = probe_inc;
          probe_next = probe_inc;
          pcnt_next  = pcnt + CNTW'(1);
        end
      end
      ltlp_pkg::S_OUT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ltlp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ltlp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe     <= '0;
      pcnt      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      probe <= probe_next;
      pcnt  <= pcnt_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_held   <= res_held_next;
    if (accept) begin
      op    <= ltlp_pkg::op_t'(req.operation);
      key   <= req.lock_key[KB-1:0];
      rtype <= req.requested_type;
    end
    if (res_load) begin
      out_status <= res_status;
      out_held   <= res_held;
      out_count  <= count;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(SLOTS))
    else $error("live count above capacity");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ltlp_pkg::S_PROBE |-> pcnt < CNTW'(SLOTS))
    else $error("probe run past one full wrap");

  a_hash_done: assert property (@(posedge clk) disable iff (rst)
    hdone |-> state == ltlp_pkg::S_HASH)
    else $error("hash result outside hash phase");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state) == ltlp_pkg::S_PROBE)
    else $error("live count changed outside a probe decision");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ltlp_pkg::S_IDLE |-> !we)
    else $error("slot memory written while idle");
`endif

endmodule

/* dv/ltlp_lock_checker.sv */
// Lock table checker: watches both channels, predicts each response and compares it.
`timescale 1ns / 100ps

module ltlp_lock_checker
  import ltlp_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic  clk,
  input  logic  rst,
  ltlp_req_if   req,
  ltlp_rsp_if   rsp,
  output int    mismatches,
  output int    pending,
  output int    checked,
  output int    n_ok,
  output int    n_conflict,
  output int    n_full,
  output int    n_missing
);

  typedef struct packed {
    status_t             status;
    logic                held;
    logic [LIVE_W-1:0]   live;
    logic                empty;
    logic                full;
  } lock_rsp_t;

  logic [KEY_W-1:0] tbl_key  [SLOTS];
  logic             tbl_excl [SLOTS];
  logic             tbl_used [SLOTS];
  logic             tbl_gone [SLOTS];
  int unsigned      n_live;

  lock_rsp_t        rsp_q[$];
  lock_rsp_t        got;
  lock_rsp_t        want;

  function automatic lock_rsp_t apply_lock_req(op_t op, logic [KEY_W-1:0] key, logic rtype);
    lock_rsp_t r;
    int        idx;
    int        hit;
    bit        stop;
    r      = '0;
    r.status = ST_OK;
    idx    = key % SLOTS;
    hit    = -1;
    stop   = 1'b0;
    if (op == OP_ADD) begin
      r.status = ST_FULL;
      if (n_live < SLOTS) begin
        for (int n = 0; n < SLOTS && !stop; n++) begin
          if (!tbl_used[idx] || tbl_gone[idx]) begin
            tbl_key[idx]  = key;
            tbl_excl[idx] = rtype;
            tbl_used[idx] = 1'b1;
            tbl_gone[idx] = 1'b0;
            n_live++;
            r.status = ST_OK;
            stop = 1'b1;
          end else if (tbl_key[idx] == key) begin
            r.status = ST_CONFLICT;
            stop = 1'b1;
          end else begin
            idx = (idx + 1) % SLOTS;
          end
        end
      end
    end else begin
      for (int n = 0; n < SLOTS && !stop; n++) begin
        if (!tbl_used[idx]) begin
          stop = 1'b1;
        end else if (!tbl_gone[idx] && tbl_key[idx] == key) begin
          hit = idx;
          stop = 1'b1;
        end else begin
          idx = (idx + 1) % SLOTS;
        end
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (op)
          OP_REMOVE: begin
            tbl_gone[hit] = 1'b1;
            if (n_live > 0) n_live--;
          end
          OP_PROMOTE: tbl_excl[hit] = 1'b1;
          default:    r.held = tbl_excl[hit];
        endcase
      end
    end
    r.live  = n_live[LIVE_W-1:0];
    r.empty = (n_live == 0);
    r.full  = (n_live >= SLOTS);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        tbl_used[s] = 1'b0;
        tbl_gone[s] = 1'b0;
      end
      n_live = 0;
      rsp_q.delete();
      mismatches = 0;
      checked    = 0;
      n_ok       = 0;
      n_conflict = 0;
      n_full     = 0;
      n_missing  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.held_type, rsp.live_count, rsp.is_empty, rsp.is_full};
        if (rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response status=%0d held=%0d live=%0d empty=%0d full=%0d",
                   $time, got.status, got.held, got.live, got.empty, got.full);
        end else begin
          want = rsp_q.pop_front();
          checked++;
          case (want.status)
            ST_OK:       n_ok++;
            ST_CONFLICT: n_conflict++;
            ST_FULL:     n_full++;
            default:     n_missing++;
          endcase
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected status=%0d held=%0d live=%0d empty=%0d full=%0d",
                     $time, want.status, want.held, want.live, want.empty, want.full);
            $display("%0t:           actual   status=%0d held=%0d live=%0d empty=%0d full=%0d",
                     $time, got.status, got.held, got.live, got.empty, got.full);
          end
        end
      end
      if (req.valid && req.ready)
        rsp_q.push_back(apply_lock_req(op_t'(req.operation), req.lock_key, req.requested_type));
    end
    pending = rsp_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the lock table: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 100ps

module tb_top;
  import ltlp_pkg::*;

  localparam int SLOTS        = 16;
  localparam int KEY_BITS     = 32;
  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_ITEMS = 1420;
  localparam int PHASE_LEN    = 120;
  localparam int QUIET_TAIL   = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL_N       = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst;

  ltlp_req_if req_ch ();
  ltlp_rsp_if rsp_ch ();

  int          mismatches, pending, checked;
  int          n_ok, n_conflict, n_full, n_missing;
  int unsigned cycles = 0;
  int          sent = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          send_calm_left = 0;
  bit          send_calm = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_N];

  always #(CLK_PERIOD / 2) clk = ~clk;

  lock_table_linear_probe #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ltlp_lock_checker #(
    .SLOTS (SLOTS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .n_ok       (n_ok),
    .n_conflict (n_conflict),
    .n_full     (n_full),
    .n_missing  (n_missing)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_req(input op_t op, input logic [KEY_W-1:0] key, input logic rtype);
    int gap;
    gap = 0;
    if (send_calm_left == 0) begin
      send_calm_left = $urandom_range(10, 40);
      send_calm = ($urandom_range(0, 2) == 0);
    end else begin
      send_calm_left--;
    end
    if (!quiet && !send_calm && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= op;
    req_ch.lock_key       <= key;
    req_ch.requested_type <= rtype;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // response side: random stall bursts, calm stretches, one long hold-off
  initial begin : rsp_stall_gen
    int stall_left, calm_left, hold_left;
    bit calm, hold_done, nxt;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    calm       = 1'b0;
    hold_done  = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm_left = $urandom_range(20, 120);
        calm = ($urandom_range(0, 2) == 0);
      end else begin
        calm_left--;
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      rsp_ch.ready <= nxt;
    end
  end

  initial begin : stimulus
    int               mode, r, t_add, t_rem, t_pro;
    op_t              op;
    logic [KEY_W-1:0] key;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.operation      = OP_ADD;
    req_ch.lock_key       = '0;
    req_ch.requested_type = 1'b0;
    for (int p = 0; p < POOL_N; p++) key_pool[p] = $urandom;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty table
    send_req(OP_GET,     32'h0000_0000, 1'b0);
    send_req(OP_REMOVE,  32'hFFFF_FFFF, 1'b1);
    send_req(OP_PROMOTE, 32'h0000_0005, 1'b0);
    // collisions and wrap past the last slot
    send_req(OP_ADD,     32'h0000_0000, 1'b0);
    send_req(OP_ADD,     32'hFFFF_FFFF, 1'b1);
    send_req(OP_ADD,     32'h0000_0010, 1'b0);
    send_req(OP_ADD,     32'h8000_001F, 1'b0);
    send_req(OP_ADD,     32'h0000_0000, 1'b1);
    send_req(OP_GET,     32'h0000_0000, 1'b0);
    send_req(OP_PROMOTE, 32'h0000_0000, 1'b0);
    send_req(OP_GET,     32'h0000_0000, 1'b0);
    send_req(OP_PROMOTE, 32'hFFFF_FFFF, 1'b0);
    // tombstone, probe across it, duplicate hidden behind it
    send_req(OP_REMOVE,  32'h0000_0000, 1'b0);
    send_req(OP_GET,     32'h8000_001F, 1'b1);
    send_req(OP_ADD,     32'h0000_0010, 1'b1);
    send_req(OP_REMOVE,  32'h0000_0010, 1'b0);
    send_req(OP_GET,     32'h0000_0010, 1'b0);
    // fill up, add to full table, absent key over a full wrap
    for (int i = 0; i < SLOTS - 3; i++) send_req(OP_ADD, $urandom, i[0]);
    send_req(OP_ADD,     32'h5555_5555, 1'b0);
    send_req(OP_REMOVE,  32'hFFFF_FFFF, 1'b0);
    send_req(OP_GET,     32'h7FFF_FFF3, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      mode = (i / PHASE_LEN) % 3;
      if (i % PHASE_LEN == 0 && mode == 0) begin
        // refresh part of the key pool; half the new keys land near the wrap point
        for (int p = 0; p < POOL_N / 3; p++) begin
          key = $urandom;
          if ($urandom_range(0, 1)) key[3:0] = 4'(4'hE + $urandom_range(0, 2));
          key_pool[$urandom_range(0, POOL_N - 1)] = key;
        end
      end
      case (mode)
        0: begin t_add = 55; t_rem = 70; t_pro = 80; end
        1: begin t_add = 30; t_rem = 60; t_pro = 75; end
        default: begin t_add = 15; t_rem = 65; t_pro = 75; end
      endcase
      r = $urandom_range(0, 99);
      op = (r < t_add) ? OP_ADD : (r < t_rem) ? OP_REMOVE : (r < t_pro) ? OP_PROMOTE : OP_GET;
      if ($urandom_range(0, 19) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, POOL_N - 1)];
      send_req(op, key, 1'($urandom_range(0, 1)));
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked responses, with stalls on both sides.",
             sent, checked);
    $display("Statuses seen: ok %0d, conflict %0d, table full %0d, not found %0d.",
             n_ok, n_conflict, n_full, n_missing);
    if (mismatches == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ltlp_pkg.sv
hdl/ltlp_req_if.sv
hdl/ltlp_rsp_if.sv
hdl/ltlp_slot_ram.sv
hdl/ltlp_hash.sv
hdl/lock_table_linear_probe.sv
dv/ltlp_lock_checker.sv
dv/tb_top.sv
